// File: rtl/cel_pkg.sv
// shared constants, codes and types for the csr element lookup
package cel_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_NZ      = 4096;
  localparam int COL_BITS    = 16;
  localparam int WORD_BITS   = 64;

  localparam int CMD_W       = 2;
  localparam int ROW_W       = 10;
  localparam int PSLOT_W     = 11;
  localparam int OFF_W       = 13;
  localparam int ESLOT_W     = 12;
  localparam int CNT_W       = 11;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam int RO_DEPTH    = MAX_ROWS + 1;
  localparam int RO_AW       = $clog2(RO_DEPTH);
  localparam int NZ_AW       = $clog2(MAX_NZ);
  localparam int NZ_CW       = NZ_AW + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  // commands on the input port
  localparam logic [CMD_W-1:0] CMD_WR_PTR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_NZ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // operations handed to the back end
  localparam logic [1:0] OP_WR_PTR = 2'd0;
  localparam logic [1:0] OP_WR_NZ  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_BEYOND = 2'd3;

  localparam logic [STAT_W-1:0] ST_HIT    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SORTED    = 2'd2;

  // addr holds the pointer slot, the entry slot or the query row
  // word holds the pointer offset in its low bits for pointer writes
  typedef struct packed {
    logic [1:0]           op;
    logic [NZ_AW-1:0]     addr;
    logic [COL_BITS-1:0]  col;
    logic [WORD_BITS-1:0] word;
  } q_item_t;

  function automatic logic [NZ_CW-1:0] clamp_off(input logic [OFF_W-1:0] v);
    if (v > OFF_W'(MAX_NZ)) begin
      clamp_off = NZ_CW'(MAX_NZ);
    end else begin
      clamp_off = NZ_CW'(v);
    end
  endfunction

endpackage

// File: rtl/cel_front.sv
// front end: decodes commands, drops ignored ones, flags rows beyond the count
module cel_front (
  input  logic                          start,
  input  logic                          q_full,
  input  logic [cel_pkg::CMD_W-1:0]     in_command,
  input  logic [cel_pkg::PSLOT_W-1:0]   in_pointer_slot,
  input  logic [cel_pkg::OFF_W-1:0]     in_pointer_offset,
  input  logic [cel_pkg::ESLOT_W-1:0]   in_entry_slot,
  input  logic [cel_pkg::COL_BITS-1:0]  in_entry_column,
  input  logic [cel_pkg::WORD_BITS-1:0] in_entry_word,
  input  logic [cel_pkg::ROW_W-1:0]     in_query_row,
  input  logic [cel_pkg::COL_BITS-1:0]  in_query_column,
  input  logic [cel_pkg::CNT_W-1:0]     row_count,
  output logic                          push,
  output cel_pkg::q_item_t              push_item
);

  logic                      keep;
  logic [cel_pkg::CNT_W-1:0] limit;

  always_comb begin
    keep      = 1'b0;
    push_item = '0;
    limit     = (row_count > cel_pkg::CNT_W'(cel_pkg::MAX_ROWS)) ?
                cel_pkg::CNT_W'(cel_pkg::MAX_ROWS) : row_count;
    case (in_command)
      cel_pkg::CMD_WR_PTR: begin
        keep           = (in_pointer_slot <= cel_pkg::PSLOT_W'(cel_pkg::MAX_ROWS));
        push_item.op   = cel_pkg::OP_WR_PTR;
        push_item.addr = cel_pkg::NZ_AW'(in_pointer_slot);
        push_item.word = cel_pkg::WORD_BITS'(in_pointer_offset);
      end
      cel_pkg::CMD_WR_NZ: begin
        keep           = 1'b1;
        push_item.op   = cel_pkg::OP_WR_NZ;
        push_item.addr = cel_pkg::NZ_AW'(in_entry_slot);
        push_item.col  = in_entry_column;
        push_item.word = in_entry_word;
      end
      cel_pkg::CMD_LOOKUP: begin
        keep           = 1'b1;
        push_item.op   = (cel_pkg::CNT_W'(in_query_row) >= limit) ?
                         cel_pkg::OP_BEYOND : cel_pkg::OP_LOOKUP;
        push_item.addr = cel_pkg::NZ_AW'(in_query_row);
        push_item.col  = in_query_column;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = start & ~q_full & keep;

endmodule

// File: rtl/cel_queue.sv
// short fifo between the front end and the back end
module cel_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cel_pkg::q_item_t push_item,
  input  logic             pop,
  output cel_pkg::q_item_t head,
  output logic             empty,
  output logic             full
);

  cel_pkg::q_item_t            store_r [cel_pkg::QUEUE_DEPTH];
  logic [cel_pkg::Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cel_pkg::Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cel_pkg::Q_CW-1:0]    cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == cel_pkg::Q_CW'(cel_pkg::QUEUE_DEPTH));
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cel_pkg::Q_AW'(cel_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cel_pkg::Q_AW'(cel_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/cel_back.sv
// back end: matrix memories, load writes and the row scan / binary search
module cel_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cel_pkg::q_item_t              head,
  input  logic                          empty,
  output logic                          pop,
  input  logic                          values_present,
  input  logic                          sorted_search,
  output logic                          out_valid,
  output logic [cel_pkg::WORD_BITS-1:0] out_result_word,
  output logic [cel_pkg::STAT_W-1:0]    out_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PTR  = 3'd1;
  localparam logic [2:0] S_LIN  = 3'd2;
  localparam logic [2:0] S_RLO  = 3'd3;
  localparam logic [2:0] S_RHI  = 3'd4;
  localparam logic [2:0] S_BIN  = 3'd5;
  localparam logic [2:0] S_BCHK = 3'd6;
  localparam logic [2:0] S_WORD = 3'd7;

  logic [cel_pkg::OFF_W-1:0]     ro_mem   [cel_pkg::RO_DEPTH];
  logic [cel_pkg::COL_BITS-1:0]  col_mem  [cel_pkg::MAX_NZ];
  logic [cel_pkg::WORD_BITS-1:0] word_mem [cel_pkg::MAX_NZ];

  logic [2:0]                    state_r, state_nxt;
  logic [cel_pkg::COL_BITS-1:0]  qcol_r, qcol_nxt;
  logic [cel_pkg::NZ_CW-1:0]     idx_r, idx_nxt;
  logic [cel_pkg::NZ_CW-1:0]     end_r, end_nxt;
  logic [cel_pkg::NZ_CW-1:0]     first_r, first_nxt;
  logic [cel_pkg::NZ_CW-1:0]     count_r, count_nxt;
  logic [cel_pkg::NZ_AW-1:0]     mid_r, mid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [cel_pkg::WORD_BITS-1:0] out_word_r, out_word_nxt;
  logic [cel_pkg::STAT_W-1:0]    out_status_r, out_status_nxt;

  logic [cel_pkg::OFF_W-1:0]     ro_rd0_r, ro_rd1_r;
  logic [cel_pkg::COL_BITS-1:0]  col_rd_r;
  logic [cel_pkg::WORD_BITS-1:0] word_rd_r;

  logic [cel_pkg::RO_AW-1:0]     ro_raddr0, ro_raddr1;
  logic [cel_pkg::NZ_AW-1:0]     col_raddr, word_raddr;
  logic                          ro_we, nz_we;

  logic [cel_pkg::NZ_CW-1:0]     start_c, end_c, idx_inc, cnt0, mid0;
  logic [cel_pkg::NZ_CW-1:0]     half, f_n, c_n, m_n;
  logic                          lt;

  assign ro_raddr0 = cel_pkg::RO_AW'(head.addr[cel_pkg::ROW_W-1:0]);
  assign ro_raddr1 = ro_raddr0 + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    qcol_nxt       = qcol_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    mid_nxt        = mid_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    pop            = 1'b0;
    ro_we          = 1'b0;
    nz_we          = 1'b0;
    col_raddr      = '0;
    word_raddr     = '0;

    start_c = cel_pkg::clamp_off(ro_rd0_r);
    end_c   = cel_pkg::clamp_off(ro_rd1_r);
    idx_inc = idx_r + 1'b1;
    cnt0    = end_r - idx_r;
    mid0    = idx_r + (cnt0 >> 1);
    lt      = (col_rd_r < qcol_r);
    half    = count_r >> 1;
    f_n     = lt ? (cel_pkg::NZ_CW'(mid_r) + 1'b1) : first_r;
    c_n     = lt ? (count_r - half - 1'b1) : half;
    m_n     = f_n + (c_n >> 1);

    case (state_r)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.op)
            cel_pkg::OP_WR_PTR: ro_we = 1'b1;
            cel_pkg::OP_WR_NZ:  nz_we = 1'b1;
            cel_pkg::OP_LOOKUP: begin
              qcol_nxt  = head.col;
              state_nxt = S_PTR;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_word_nxt   = '0;
              out_status_nxt = cel_pkg::ST_BEYOND;
            end
          endcase
        end
      end
      S_PTR: begin
        if (start_c >= end_c) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_status_nxt = cel_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          col_raddr = start_c[cel_pkg::NZ_AW-1:0];
          idx_nxt   = start_c;
          end_nxt   = end_c;
          state_nxt = sorted_search ? S_RLO : S_LIN;
        end
      end
      S_LIN: begin
        if (col_rd_r == qcol_r) begin
          word_raddr = idx_r[cel_pkg::NZ_AW-1:0];
          state_nxt  = S_WORD;
        end else if (idx_inc >= end_r) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_status_nxt = cel_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          col_raddr = idx_inc[cel_pkg::NZ_AW-1:0];
        end
      end
      S_RLO: begin
        // query below the row's first column
        if (qcol_r < col_rd_r) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_status_nxt = cel_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          col_raddr = cel_pkg::NZ_AW'(end_r - 1'b1);
          state_nxt = S_RHI;
        end
      end
      S_RHI: begin
        if (qcol_r > col_rd_r) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_status_nxt = cel_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          first_nxt = idx_r;
          count_nxt = cnt0;
          mid_nxt   = mid0[cel_pkg::NZ_AW-1:0];
          col_raddr = mid0[cel_pkg::NZ_AW-1:0];
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        // one lower-bound step, col_rd_r holds the column at mid
        first_nxt = f_n;
        count_nxt = c_n;
        if (c_n != '0) begin
          mid_nxt   = m_n[cel_pkg::NZ_AW-1:0];
          col_raddr = m_n[cel_pkg::NZ_AW-1:0];
        end else begin
          col_raddr = f_n[cel_pkg::NZ_AW-1:0];
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (first_r >= end_r || col_rd_r != qcol_r) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_status_nxt = cel_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          word_raddr = first_r[cel_pkg::NZ_AW-1:0];
          state_nxt  = S_WORD;
        end
      end
      S_WORD: begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = values_present ? word_rd_r : cel_pkg::WORD_BITS'(1);
        out_status_nxt = cel_pkg::ST_HIT;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qcol_r       <= qcol_nxt;
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    first_r      <= first_nxt;
    count_r      <= count_nxt;
    mid_r        <= mid_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
  end

  // row pointer memory: one write port, two read ports
  always_ff @(posedge clk) begin
    if (ro_we) begin
      ro_mem[head.addr[cel_pkg::RO_AW-1:0]] <= head.word[cel_pkg::OFF_W-1:0];
    end
    ro_rd0_r <= ro_mem[ro_raddr0];
    ro_rd1_r <= ro_mem[ro_raddr1];
  end

  always_ff @(posedge clk) begin
    if (nz_we) begin
      col_mem[head.addr] <= head.col;
    end
    col_rd_r <= col_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (nz_we) begin
      word_mem[head.addr] <= head.word;
    end
    word_rd_r <= word_mem[word_raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_status      = out_status_r;

endmodule

// File: rtl/csr_element_lookup.sv
// csr element lookup: a row beyond the count gives status beyond and an empty row a miss; linear
// search compares the row's entries in turn; sorted search checks the first and last columns of
// the row, then runs a lower-bound binary search; a load passes through the queue and is written
// when the back end pops it, one load per cycle while the back end is idle; one item runs in the
// back end at a time, which has a single column memory read port, and a 2-item queue lets start
// be taken meanwhile; results cannot be stalled; sync reset clears control and config only
module csr_element_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [cel_pkg::CMD_W-1:0]      in_command,
  input  logic [cel_pkg::PSLOT_W-1:0]    in_pointer_slot,
  input  logic [cel_pkg::OFF_W-1:0]      in_pointer_offset,
  input  logic [cel_pkg::ESLOT_W-1:0]    in_entry_slot,
  input  logic [cel_pkg::COL_BITS-1:0]   in_entry_column,
  input  logic [cel_pkg::WORD_BITS-1:0]  in_entry_word,
  input  logic [cel_pkg::ROW_W-1:0]      in_query_row,
  input  logic [cel_pkg::COL_BITS-1:0]   in_query_column,
  output logic                           out_valid,
  output logic [cel_pkg::WORD_BITS-1:0]  out_result_word,
  output logic [cel_pkg::STAT_W-1:0]     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cel_pkg::CNT_W-1:0]      cfg_data
);

  logic [cel_pkg::CNT_W-1:0] row_count_r;
  logic                      values_r;
  logic                      sorted_r;
  logic                      q_full, q_empty, push, pop;
  cel_pkg::q_item_t          push_item, head;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      values_r    <= 1'b1;
      sorted_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cel_pkg::CFG_ROW_COUNT: row_count_r <= cfg_data;
        cel_pkg::CFG_VALUES:    values_r    <= cfg_data[0];
        cel_pkg::CFG_SORTED:    sorted_r    <= cfg_data[0];
        default:                ;
      endcase
    end
  end

  cel_front u_front (
    .start             (start),
    .q_full            (q_full),
    .in_command        (in_command),
    .in_pointer_slot   (in_pointer_slot),
    .in_pointer_offset (in_pointer_offset),
    .in_entry_slot     (in_entry_slot),
    .in_entry_column   (in_entry_column),
    .in_entry_word     (in_entry_word),
    .in_query_row      (in_query_row),
    .in_query_column   (in_query_column),
    .row_count         (row_count_r),
    .push              (push),
    .push_item         (push_item)
  );

  cel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cel_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .values_present  (values_r),
    .sorted_search   (sorted_r),
    .out_valid       (out_valid),
    .out_result_word (out_result_word),
    .out_status      (out_status)
  );

endmodule
